@@ rtl/section_table_address_translator_top_assert.svh @@
// Assertion macros for the section table translator.
// SAT_ASSERT checks a property on every clock edge outside reset.
// SAT_ASSERT_NEXT checks that a condition leads to another in the next cycle.
`ifndef SECTION_TABLE_ADDRESS_TRANSLATOR_TOP_ASSERT_SVH
`define SECTION_TABLE_ADDRESS_TRANSLATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define SAT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define SAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SAT_ASSERT(lbl, prop, msg)

`define SAT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/sat_pkg.sv @@
`timescale 1ns / 1ps

package sat_pkg;

    // Table geometry
    localparam int MAX_SECTIONS = 16;
    localparam int IDX_W        = $clog2(MAX_SECTIONS);
    localparam int CNT_W        = $clog2(MAX_SECTIONS + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_BASE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTION_COUNT = 1'b1;

    // Operation codes
    localparam logic [2:0] OP_WRITE    = 3'd0;
    localparam logic [2:0] OP_OFF2ADDR = 3'd1;
    localparam logic [2:0] OP_ADDR2OFF = 3'd2;
    localparam logic [2:0] OP_ABS2OFF  = 3'd3;
    localparam logic [2:0] OP_FIND     = 3'd4;

    localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  entry_index;
        logic [31:0] raw_pointer;
        logic [31:0] raw_size;
        logic [31:0] virtual_base;
        logic [63:0] entry_name;
        logic [31:0] query_value;
        logic [63:0] name_key;
        logic        name_filter_on;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic        found;
        logic [3:0]  section_index;
    } out_beat_t;

    typedef struct packed {
        logic [31:0] raw_start;
        logic [31:0] raw_length;
        logic [31:0] virtual_base;
        logic [63:0] label;
    } entry_t;

    // Cut a name at its first zero byte; later bytes read as zero
    function automatic logic [63:0] cut_name(input logic [63:0] name);
        logic [63:0] cut;
        logic        keep;
        cut  = '0;
        keep = 1'b1;
        for (int b = 0; b < 8; b++)
        begin
            if (name[8*b +: 8] == 8'h00)
            begin
                keep = 1'b0;
            end
            if (keep)
            begin
                cut[8*b +: 8] = name[8*b +: 8];
            end
        end
        return cut;
    endfunction

endpackage

@@ rtl/section_table_address_translator_top.sv @@
`timescale 1ns / 1ps

// Section table translator. Sixteen section entries sit in one synchronous
// memory with a single port; a write beat loads one slot and answers through
// the done state and the output register. A query reads the entries 0 ..
// min(section_count, 16)-1 one per cycle through that port, into a
// two-stage compare pipeline, and stops at the first hit; when section_count
// is zero it answers as a miss without a read. One beat is in flight at a
// time; the next is taken once the result has moved to the output register,
// even while that register is still stalled. Configuration writes take
// effect on the next edge; the user must make them only while idle, and the
// block itself does not enforce this. Entries that were never written hold
// undefined contents.
`include "section_table_address_translator_top_assert.svh"

module section_table_address_translator_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [sat_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sat_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  sat_pkg::in_beat_t                   in_beat,
    output logic                                out_valid,
    input  logic                                out_stall,
    output sat_pkg::out_beat_t                  out_beat
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Control and configuration
    state_t                         state_reg, state_next;
    logic [31:0]                    image_base_reg, image_base_next;
    logic [sat_pkg::CNT_W-1:0]      section_count_reg, section_count_next;

    // Query context held for the scan
    logic [2:0]                     op_reg, op_next;
    logic [31:0]                    q_reg, q_next;
    logic [31:0]                    qmb_reg, qmb_next;
    logic [63:0]                    key_reg, key_next;
    logic                           filter_reg, filter_next;

    // Scan pipeline
    logic [sat_pkg::CNT_W-1:0]      issue_idx_reg, issue_idx_next;
    logic                           rd_valid_reg, rd_valid_next;
    logic [sat_pkg::IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                           s1_valid_reg, s1_valid_next;
    logic [sat_pkg::IDX_W-1:0]      s1_idx_reg, s1_idx_next;
    logic [31:0]                    s1_off_reg, s1_off_next;
    logic [31:0]                    s1_start_reg, s1_start_next;
    logic [31:0]                    s1_stop_reg, s1_stop_next;
    logic [31:0]                    s1_res1_reg, s1_res1_next;
    logic                           s1_name_ok_reg, s1_name_ok_next;

    // Result and output
    sat_pkg::out_beat_t             res_reg, res_next;
    logic                           out_valid_reg, out_valid_next;
    sat_pkg::out_beat_t             out_reg, out_next;

    // Memory
    sat_pkg::entry_t                mem [sat_pkg::MAX_SECTIONS];
    sat_pkg::entry_t                rd_data_reg;
    sat_pkg::entry_t                wr_entry;
    logic                           mem_we;
    logic                           mem_re;

    logic                           in_accept;
    logic                           out_free;
    logic [sat_pkg::CNT_W-1:0]      scan_lim;
    logic                           issue_more;
    logic                           range_ok;
    logic                           s1_match;
    logic                           hit_now;
    logic                           miss_now;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Clamp the scan length to the table depth
    assign scan_lim = (section_count_reg > sat_pkg::CNT_W'(sat_pkg::MAX_SECTIONS))
                    ? sat_pkg::CNT_W'(sat_pkg::MAX_SECTIONS) : section_count_reg;
    assign issue_more = (issue_idx_reg < scan_lim);

    // Decide on the entry in the second stage
    assign range_ok = (s1_off_reg >= s1_start_reg) && (s1_off_reg < s1_stop_reg);
    assign s1_match = (op_reg == sat_pkg::OP_FIND) ? s1_name_ok_reg
                    : ((!filter_reg || s1_name_ok_reg) && range_ok);
    assign hit_now  = (state_reg == ST_SCAN) && s1_valid_reg && s1_match;
    assign miss_now = (state_reg == ST_SCAN) && !issue_more && !rd_valid_reg && !s1_valid_reg;

    // Writes happen only on acceptance in idle, reads only during a scan
    assign mem_we = in_accept && (in_beat.operation == sat_pkg::OP_WRITE)
                  && ({1'b0, in_beat.entry_index} < sat_pkg::CNT_W'(sat_pkg::MAX_SECTIONS));
    assign mem_re = (state_reg == ST_SCAN) && issue_more && !hit_now;

    always_comb
    begin
        wr_entry.raw_start    = in_beat.raw_pointer;
        wr_entry.raw_length   = in_beat.raw_size;
        wr_entry.virtual_base = in_beat.virtual_base;
        wr_entry.label        = in_beat.entry_name;
    end

    // Section memory: one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[in_beat.entry_index] <= wr_entry;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[issue_idx_reg[sat_pkg::IDX_W-1:0]];
        end
    end

    // Next-state logic
    always_comb
    begin
        state_next         = state_reg;
        image_base_next    = image_base_reg;
        section_count_next = section_count_reg;
        op_next            = op_reg;
        q_next             = q_reg;
        qmb_next           = qmb_reg;
        key_next           = key_reg;
        filter_next        = filter_reg;
        issue_idx_next     = issue_idx_reg;
        rd_valid_next      = 1'b0;
        rd_idx_next        = rd_idx_reg;
        s1_valid_next      = 1'b0;
        s1_idx_next        = s1_idx_reg;
        s1_off_next        = s1_off_reg;
        s1_start_next      = s1_start_reg;
        s1_stop_next       = s1_stop_reg;
        s1_res1_next       = s1_res1_reg;
        s1_name_ok_next    = s1_name_ok_reg;
        res_next           = res_reg;
        out_valid_next     = out_valid_reg && out_stall;
        out_next           = out_reg;

        // Take configuration writes
        if (cfg_write)
        begin
            case (cfg_index)
                sat_pkg::CFG_IMAGE_BASE:    image_base_next = cfg_data;
                sat_pkg::CFG_SECTION_COUNT: section_count_next = cfg_data[sat_pkg::CNT_W-1:0];
                default:                    image_base_next = image_base_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next        = in_beat.operation;
                    q_next         = in_beat.query_value;
                    qmb_next       = in_beat.query_value - image_base_reg;
                    key_next       = sat_pkg::cut_name(in_beat.name_key);
                    filter_next    = in_beat.name_filter_on;
                    issue_idx_next = '0;
                    res_next.result_value  = sat_pkg::MISS_VALUE;
                    res_next.found         = 1'b0;
                    res_next.section_index = '0;
                    if (mem_we)
                    begin
                        res_next.found         = 1'b1;
                        res_next.section_index = in_beat.entry_index;
                    end
                    if ((in_beat.operation >= sat_pkg::OP_OFF2ADDR)
                        && (in_beat.operation <= sat_pkg::OP_FIND))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_SCAN:
            begin
                // Issue the next read
                if (mem_re)
                begin
                    issue_idx_next = issue_idx_reg + 1'b1;
                    rd_valid_next  = 1'b1;
                    rd_idx_next    = issue_idx_reg[sat_pkg::IDX_W-1:0];
                end
                // First stage: offsets, bounds and name compare
                if (rd_valid_reg && !hit_now)
                begin
                    s1_valid_next = 1'b1;
                    s1_idx_next   = rd_idx_reg;
                    s1_start_next = rd_data_reg.raw_start;
                    s1_stop_next  = rd_data_reg.raw_start + rd_data_reg.raw_length;
                    s1_res1_next  = (q_reg - rd_data_reg.raw_start)
                                  + (rd_data_reg.virtual_base + image_base_reg);
                    s1_name_ok_next = (sat_pkg::cut_name(rd_data_reg.label) == key_reg);
                    case (op_reg)
                        sat_pkg::OP_OFF2ADDR: s1_off_next = q_reg;
                        sat_pkg::OP_ADDR2OFF:
                            s1_off_next = (qmb_reg - rd_data_reg.virtual_base)
                                        + rd_data_reg.raw_start;
                        default:              s1_off_next = qmb_reg;
                    endcase
                end
                // Finish on the first hit, or once every entry has been seen
                if (hit_now)
                begin
                    res_next.found         = 1'b1;
                    res_next.section_index = s1_idx_reg;
                    case (op_reg)
                        sat_pkg::OP_FIND:     res_next.result_value = sat_pkg::MISS_VALUE;
                        sat_pkg::OP_OFF2ADDR: res_next.result_value = s1_res1_reg;
                        default:              res_next.result_value = s1_off_reg;
                    endcase
                    rd_valid_next = 1'b0;
                    s1_valid_next = 1'b0;
                    state_next    = ST_DONE;
                end
                else if (miss_now)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Move the result to the output register once it is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            image_base_reg    <= '0;
            section_count_reg <= '0;
            op_reg            <= '0;
            q_reg             <= '0;
            qmb_reg           <= '0;
            key_reg           <= '0;
            filter_reg        <= 1'b0;
            issue_idx_reg     <= '0;
            rd_valid_reg      <= 1'b0;
            rd_idx_reg        <= '0;
            s1_valid_reg      <= 1'b0;
            s1_idx_reg        <= '0;
            s1_off_reg        <= '0;
            s1_start_reg      <= '0;
            s1_stop_reg       <= '0;
            s1_res1_reg       <= '0;
            s1_name_ok_reg    <= 1'b0;
            res_reg           <= '0;
            out_valid_reg     <= 1'b0;
            out_reg           <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            image_base_reg    <= image_base_next;
            section_count_reg <= section_count_next;
            op_reg            <= op_next;
            q_reg             <= q_next;
            qmb_reg           <= qmb_next;
            key_reg           <= key_next;
            filter_reg        <= filter_next;
            issue_idx_reg     <= issue_idx_next;
            rd_valid_reg      <= rd_valid_next;
            rd_idx_reg        <= rd_idx_next;
            s1_valid_reg      <= s1_valid_next;
            s1_idx_reg        <= s1_idx_next;
            s1_off_reg        <= s1_off_next;
            s1_start_reg      <= s1_start_next;
            s1_stop_reg       <= s1_stop_next;
            s1_res1_reg       <= s1_res1_next;
            s1_name_ok_reg    <= s1_name_ok_next;
            res_reg           <= res_next;
            out_valid_reg     <= out_valid_next;
            out_reg           <= out_next;
        end
    end

    // Checks
    `SAT_ASSERT(a_no_rw_overlap, !(mem_we && mem_re), "memory read and write in one cycle")
    `SAT_ASSERT(a_pipe_in_scan, !(rd_valid_reg || s1_valid_reg) || (state_reg == ST_SCAN), "scan pipeline busy outside a scan")
    `SAT_ASSERT(a_issue_bound, issue_idx_reg <= sat_pkg::CNT_W'(sat_pkg::MAX_SECTIONS), "read index past the table")
    `SAT_ASSERT_NEXT(a_write_found, mem_we, res_reg.found && (state_reg == ST_DONE), "write beat not answered as found")

endmodule

@@ tb/section_table_checker.sv @@
`timescale 1ns / 1ps

module section_table_checker
    import sat_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  in_beat_t                in_beat,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  out_beat_t               out_beat,
    output int                      fail_count,
    output int                      pending
);

    // Shadow of the section table and the two registers
    entry_t      section_shadow [MAX_SECTIONS];
    logic [31:0] load_base;
    logic [4:0]  scan_count;

    // Translations still owed by the block, oldest first
    out_beat_t   owed_answers [$];
    out_beat_t   want;

    // Keep the bytes below the first zero byte, clear the rest
    function automatic logic [63:0] trim_label(input logic [63:0] n);
        int z;
        int k;
        z = 8;
        for (k = 7; k >= 0; k--)
        begin
            if (n[8*k +: 8] == 8'h00)
            begin
                z = k;
            end
        end
        if (z == 0)
        begin
            return 64'h0;
        end
        return n & ({64{1'b1}} >> (64 - 8 * z));
    endfunction

    // Work out the answer to one beat from the current shadow
    function automatic out_beat_t translate_beat(input in_beat_t b);
        out_beat_t   r;
        logic [63:0] key;
        logic [31:0] start;
        logic [31:0] stop;
        logic [31:0] off;
        int          lim;
        int          i;
        logic        done;
        r.result_value  = MISS_VALUE;
        r.found         = 1'b0;
        r.section_index = '0;
        key  = trim_label(b.name_key);
        lim  = (scan_count > MAX_SECTIONS) ? MAX_SECTIONS : int'(scan_count);
        done = 1'b0;
        case (b.operation)
            OP_WRITE:
            begin
                r.found         = 1'b1;
                r.section_index = b.entry_index;
            end
            OP_OFF2ADDR, OP_ADDR2OFF, OP_ABS2OFF:
            begin
                for (i = 0; i < lim; i++)
                begin
                    if (!done && !(b.name_filter_on &&
                                   trim_label(section_shadow[i].label) != key))
                    begin
                        start = section_shadow[i].raw_start;
                        stop  = start + section_shadow[i].raw_length;
                        if (b.operation == OP_OFF2ADDR)
                        begin
                            off = b.query_value;
                        end
                        else if (b.operation == OP_ADDR2OFF)
                        begin
                            off = b.query_value - section_shadow[i].virtual_base
                                  - load_base + start;
                        end
                        else
                        begin
                            off = b.query_value - load_base;
                        end
                        if (off >= start && off < stop)
                        begin
                            if (b.operation == OP_OFF2ADDR)
                            begin
                                r.result_value = b.query_value - start
                                                 + section_shadow[i].virtual_base
                                                 + load_base;
                            end
                            else
                            begin
                                r.result_value = off;
                            end
                            r.found         = 1'b1;
                            r.section_index = i[3:0];
                            done            = 1'b1;
                        end
                    end
                end
            end
            OP_FIND:
            begin
                for (i = 0; i < lim; i++)
                begin
                    if (!done && trim_label(section_shadow[i].label) == key)
                    begin
                        r.found         = 1'b1;
                        r.section_index = i[3:0];
                        done            = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Retire result beats, then predict input beats, then track registers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SECTIONS; i++)
            begin
                section_shadow[i] = '0;
            end
            load_base  = '0;
            scan_count = '0;
            owed_answers.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_answers.size() == 0)
                begin
                    $error("result beat with nothing expected: %h", out_beat);
                    fail_count++;
                end
                else
                begin
                    want = owed_answers.pop_front();
                    if (out_beat.result_value !== want.result_value)
                    begin
                        $error("result_value expected %h actual %h",
                               want.result_value, out_beat.result_value);
                        fail_count++;
                    end
                    if (out_beat.found !== want.found)
                    begin
                        $error("found expected %b actual %b", want.found, out_beat.found);
                        fail_count++;
                    end
                    if (out_beat.section_index !== want.section_index)
                    begin
                        $error("section_index expected %0d actual %0d",
                               want.section_index, out_beat.section_index);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                owed_answers.push_back(translate_beat(in_beat));
                if (in_beat.operation == OP_WRITE)
                begin
                    section_shadow[in_beat.entry_index].raw_start    = in_beat.raw_pointer;
                    section_shadow[in_beat.entry_index].raw_length   = in_beat.raw_size;
                    section_shadow[in_beat.entry_index].virtual_base = in_beat.virtual_base;
                    section_shadow[in_beat.entry_index].label        = in_beat.entry_name;
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_IMAGE_BASE:    load_base  = cfg_data;
                    CFG_SECTION_COUNT: scan_count = cfg_data[4:0];
                    default:           ;
                endcase
            end
            pending = owed_answers.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import sat_pkg::*;

    localparam logic [2:0] OP_LAST   = 3'd7;
    localparam int POOL_SIZE         = 8;
    localparam int SETTLE_CYCLES     = 30;
    localparam int PHASES            = 6;
    localparam int ITEMS_PER_PHASE   = 100;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    in_beat_t               in_beat;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_beat_t              out_beat;
    int                     fail_count;
    int                     pending;

    // Stimulus-side memory of what was loaded, used only to aim queries
    logic [31:0] sent_start [MAX_SECTIONS];
    logic [31:0] sent_size  [MAX_SECTIONS];
    logic [31:0] sent_vbase [MAX_SECTIONS];
    logic [63:0] sent_name  [MAX_SECTIONS];
    logic [63:0] name_pool  [POOL_SIZE];
    logic [31:0] base_now;
    int          idle_pct;
    int          stall_pct;

    section_table_address_translator_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat)
    );

    section_table_checker i_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_beat    (in_beat),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_beat   (out_beat),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop for a hung run
    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Stall the result side at the phase's rate
    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    // Fill the bytes above the first zero byte with garbage
    function automatic logic [63:0] dirty_label(input logic [63:0] n);
        logic [63:0] d;
        int          z;
        int          k;
        d = n;
        z = 8;
        for (k = 7; k >= 0; k--)
        begin
            if (n[8*k +: 8] == 8'h00)
            begin
                z = k;
            end
        end
        for (k = z + 1; k < 8; k++)
        begin
            d[8*k +: 8] = 8'($urandom_range(0, 255));
        end
        return d;
    endfunction

    function automatic logic [63:0] random_label();
        logic [63:0] n;
        n = name_pool[$urandom_range(0, POOL_SIZE - 1)];
        if ($urandom_range(99) < 30)
        begin
            n = dirty_label(n);
        end
        return n;
    endfunction

    function automatic in_beat_t noise_beat();
        in_beat_t b;
        b.operation      = 3'($urandom_range(0, OP_LAST));
        b.entry_index    = 4'($urandom_range(0, MAX_SECTIONS - 1));
        b.raw_pointer    = $urandom;
        b.raw_size       = $urandom;
        b.virtual_base   = $urandom;
        b.entry_name     = {$urandom, $urandom};
        b.query_value    = $urandom;
        b.name_key       = {$urandom, $urandom};
        b.name_filter_on = 1'($urandom_range(0, 1));
        return b;
    endfunction

    // Section load with mostly small ranges, a few empty, huge or wrapping
    function automatic in_beat_t random_entry(input int slot);
        in_beat_t b;
        int       pick;
        b             = noise_beat();
        b.operation   = OP_WRITE;
        b.entry_index = 4'(slot);
        pick = $urandom_range(9);
        if (pick < 6)
        begin
            b.raw_size = $urandom_range(1, 4096);
        end
        else if (pick == 6)
        begin
            b.raw_size = 32'h0;
        end
        else if (pick == 7)
        begin
            b.raw_size = 32'hFFFF_FFFF;
        end
        pick = $urandom_range(9);
        if (pick == 0)
        begin
            b.raw_pointer = 32'h0;
        end
        else if (pick == 1)
        begin
            b.raw_pointer = 32'hFFFF_FFFF - $urandom_range(0, 4096);
        end
        b.entry_name = random_label();
        return b;
    endfunction

    // Query aimed at or just around one loaded section
    function automatic in_beat_t aimed_query(input int j, input logic [2:0] op);
        in_beat_t    b;
        logic [31:0] delta;
        logic [31:0] off;
        int          pick;
        b           = noise_beat();
        b.operation = op;
        pick = $urandom_range(9);
        if (sent_size[j] == 0)
        begin
            delta = $urandom;
        end
        else if (pick == 0)
        begin
            delta = 32'h0;
        end
        else if (pick == 1)
        begin
            delta = sent_size[j] - 1;
        end
        else if (pick == 2)
        begin
            delta = sent_size[j];
        end
        else
        begin
            delta = $urandom % sent_size[j];
        end
        off = sent_start[j] + delta;
        case (op)
            OP_OFF2ADDR: b.query_value = off;
            OP_ADDR2OFF: b.query_value = off - sent_start[j] + sent_vbase[j] + base_now;
            default:     b.query_value = off + base_now;
        endcase
        b.name_filter_on = ($urandom_range(99) < 40);
        if (b.name_filter_on)
        begin
            b.name_key = ($urandom_range(99) < 70) ? dirty_label(sent_name[j]) : random_label();
        end
        return b;
    endfunction

    // Present one beat after a random gap and hold it until taken
    task automatic send_beat(input in_beat_t b);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_beat  <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        if (b.operation == OP_WRITE)
        begin
            sent_start[b.entry_index] = b.raw_pointer;
            sent_size[b.entry_index]  = b.raw_size;
            sent_vbase[b.entry_index] = b.virtual_base;
            sent_name[b.entry_index]  = b.entry_name;
        end
        @(negedge clk);
    endtask

    // Drop valid and wait for the block to fall quiet
    task automatic settle_block();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write both registers on back-to-back cycles
    task automatic configure(input logic [31:0] ib, input logic [4:0] cnt);
        cfg_write <= 1'b1;
        cfg_index <= CFG_IMAGE_BASE;
        cfg_data  <= ib;
        @(negedge clk);
        cfg_index <= CFG_SECTION_COUNT;
        cfg_data  <= {27'h0, cnt};
        @(negedge clk);
        cfg_write <= 1'b0;
        base_now  = ib;
    endtask

    initial
    begin
        in_beat_t    b;
        logic [31:0] ib;
        logic [4:0]  cnt;
        int          len;
        int          r;
        int          p;
        int          n;
        int          k;

        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_beat   = '0;
        idle_pct  = 0;
        stall_pct = 0;
        base_now  = '0;

        // Name pool: the empty name plus short random names
        name_pool[0] = 64'h0;
        for (p = 1; p < POOL_SIZE; p++)
        begin
            len          = $urandom_range(1, 8);
            name_pool[p] = 64'h0;
            for (k = 0; k < len; k++)
            begin
                name_pool[p][8*k +: 8] = 8'($urandom_range(1, 255));
            end
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Queries against an empty scan, and one unused code
        b = noise_beat();
        b.operation = OP_OFF2ADDR;
        send_beat(b);
        b = noise_beat();
        b.operation = OP_FIND;
        send_beat(b);
        b = noise_beat();
        b.operation = OP_ABS2OFF;
        send_beat(b);
        b = noise_beat();
        b.operation = OP_LAST;
        send_beat(b);

        // Load every slot, the first few with extreme ranges and names
        for (k = 0; k < MAX_SECTIONS; k++)
        begin
            b = random_entry(k);
            case (k)
                0:
                begin
                    b.raw_pointer  = 32'h0;
                    b.raw_size     = 32'hFFFF_FFFF;
                    b.virtual_base = 32'h0;
                end
                1:
                begin
                    b.raw_pointer  = 32'hFFFF_FFFF;
                    b.raw_size     = 32'h1;
                    b.virtual_base = 32'hFFFF_FFFF;
                    b.entry_name   = 64'hFFFF_FFFF_FFFF_FFFF;
                end
                2:
                begin
                    b.raw_size   = 32'h0;
                    b.entry_name = 64'h0;
                end
                3:
                begin
                    b.raw_pointer  = 32'h0000_1000;
                    b.raw_size     = 32'h0000_0200;
                    b.virtual_base = 32'h0000_2000;
                    b.entry_name   = 64'h5A5A_5A00_7478_652E;
                end
                default:
                begin
                end
            endcase
            send_beat(b);
        end

        settle_block();
        configure(32'h0040_0000, 5'd16);

        // One of each translation, a find, a filtered lookup and an unused code
        b = aimed_query(0, OP_OFF2ADDR);
        b.query_value    = 32'h0;
        b.name_filter_on = 1'b0;
        send_beat(b);
        send_beat(aimed_query(7, OP_ADDR2OFF));
        b = aimed_query(5, OP_ABS2OFF);
        b.query_value = 32'hFFFF_FFFF;
        send_beat(b);
        b = noise_beat();
        b.operation = OP_FIND;
        b.name_key  = dirty_label(sent_name[9]);
        send_beat(b);
        b = aimed_query(6, OP_OFF2ADDR);
        b.name_filter_on = 1'b1;
        b.name_key       = sent_name[6];
        send_beat(b);
        b = noise_beat();
        b.operation = OP_FIND + 3'd2;
        send_beat(b);

        // Random phases, each under its own registers and one of four pacings
        for (p = 0; p < PHASES; p++)
        begin
            settle_block();
            case (p)
                0:       begin ib = 32'h0;          cnt = 5'd16; end
                1:       begin ib = 32'hFFFF_FFFF;  cnt = 5'd31; end
                2:       begin ib = $urandom;       cnt = 5'd0;  end
                3:       begin ib = 32'h0040_0000;  cnt = 5'd16; end
                4:       begin ib = $urandom;       cnt = 5'd1;  end
                default: begin ib = $urandom;       cnt = 5'($urandom_range(2, 15)); end
            endcase
            configure(ib, cnt);
            case (p % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 87; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 87; end
                default: begin idle_pct = 16; stall_pct = 16; end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                r = $urandom_range(99);
                if (r < 20)
                begin
                    b = random_entry($urandom_range(0, MAX_SECTIONS - 1));
                end
                else if (r < 85)
                begin
                    b = aimed_query($urandom_range(0, MAX_SECTIONS - 1),
                                    3'($urandom_range(OP_OFF2ADDR, OP_ABS2OFF)));
                end
                else if (r < 93)
                begin
                    b = noise_beat();
                    b.operation = OP_FIND;
                    b.name_key  = ($urandom_range(1) == 1)
                                  ? dirty_label(sent_name[$urandom_range(0, MAX_SECTIONS - 1)])
                                  : random_label();
                end
                else
                begin
                    b = noise_beat();
                end
                send_beat(b);
            end
        end

        settle_block();
        if (fail_count == 0 && pending == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
